/* rtl/llds_pkg.sv */
// ----------------------------------------------------------------------------
// llds_pkg
// Shared constants, codes and types for the newest-first value list.
// ----------------------------------------------------------------------------
package llds_pkg;

  // List geometry
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 35;
  localparam int COUNT_W  = 5;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_SUM    = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             push;      // shift away from head, load new head
    logic             scan;      // rotate one place towards the head
    logic             keep_head; // recirculate the head entry to the tail
    logic [IDX_W-1:0] tail_idx;  // slot that takes the recirculated head
  } cell_ctl_t;

endpackage

/* rtl/llds_if.sv */
// ----------------------------------------------------------------------------
// llds_in_if / llds_out_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface llds_in_if;
  logic                              valid;
  logic                              ready;
  logic [llds_pkg::KIND_W-1:0]       kind;
  logic signed [llds_pkg::VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface llds_out_if;
  logic                          valid;
  logic                          ready;
  logic [llds_pkg::STATUS_W-1:0] status;
  logic [llds_pkg::TOTAL_W-1:0]  total;
  logic [llds_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output total, output count, input ready);
  modport sink   (input valid, input status, input total, input count, output ready);
endinterface

/* rtl/llds_cell.sv */
// ----------------------------------------------------------------------------
// llds_cell
// One list slot: holds an entry and moves it to or from its neighbours.
// ----------------------------------------------------------------------------
module llds_cell (
  input  logic                           clk,
  input  llds_pkg::cell_ctl_t            ctl,
  input  logic [llds_pkg::IDX_W-1:0]     cell_idx,
  input  logic [llds_pkg::VALUE_W-1:0]   prev_data,
  input  logic [llds_pkg::VALUE_W-1:0]   next_data,
  input  logic [llds_pkg::VALUE_W-1:0]   head_data,
  output logic [llds_pkg::VALUE_W-1:0]   data_q
);

  logic [llds_pkg::VALUE_W-1:0] data_r;
  logic [llds_pkg::VALUE_W-1:0] data_nxt;

  // Push takes the slot nearer the head; rotate takes the slot further away,
  // except at the tail, which takes the head entry when it is kept
  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = prev_data;
    end else if (ctl.scan) begin
      if (ctl.keep_head && (cell_idx == ctl.tail_idx)) begin
        data_nxt = head_data;
      end else begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

/* rtl/llds_chain.sv */
// ----------------------------------------------------------------------------
// llds_chain
// Row of list cells, slot 0 at the head; exposes the head entry.
// ----------------------------------------------------------------------------
module llds_chain (
  input  logic                         clk,
  input  llds_pkg::cell_ctl_t          ctl,
  input  logic [llds_pkg::VALUE_W-1:0] push_data,
  output logic [llds_pkg::VALUE_W-1:0] head_data
);

  logic [llds_pkg::VALUE_W-1:0] slot_data [llds_pkg::DEPTH];

  for (genvar i = 0; i < llds_pkg::DEPTH; i++) begin : g_cell
    logic [llds_pkg::VALUE_W-1:0] prev_w;
    logic [llds_pkg::VALUE_W-1:0] next_w;

    // Neighbour wiring; the far end shifts in don't-care zeros
    if (i == 0) begin : g_head
      assign prev_w = push_data;
    end else begin : g_mid
      assign prev_w = slot_data[i-1];
    end
    if (i == llds_pkg::DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = slot_data[i+1];
    end

    llds_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (llds_pkg::IDX_W'(i)),
      .prev_data (prev_w),
      .next_data (next_w),
      .head_data (slot_data[0]),
      .data_q    (slot_data[i])
    );
  end

  assign head_data = slot_data[0];

endmodule

/* rtl/lifo_list_delete_search.sv */
// ----------------------------------------------------------------------------
// lifo_list_delete_search
// Bounded newest-first list of signed values with insert, delete, search and
// sum of positive entries, held in a row of shifting cells.
// ----------------------------------------------------------------------------
//   Channel    Dir   Payload                    Transfer
//   in_chan    in    kind, value                valid & ready
//   out_chan   out   status, total, count       valid & ready
//
// Insert, and any operation on an empty list, answers on acceptance.
// Delete, search and sum scan the list: the cell row rotates it past the
// head, where the compare and adder sit, one entry per cycle unless stalled.
// Reset clears the entry count and the sequencer; slot contents are kept.
// A result waiting on out_chan holds off new requests and the final step.
// ----------------------------------------------------------------------------
module lifo_list_delete_search (
  input  logic             clk,
  input  logic             rst_n,
  llds_in_if.sink          in_chan,
  llds_out_if.source       out_chan
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                           state_r, state_nxt;
  logic [llds_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [llds_pkg::CNT_W-1:0]       steps_r, steps_nxt;
  logic                             found_r, found_nxt;
  llds_pkg::kind_t                  op_r, op_nxt;
  logic [llds_pkg::VALUE_W-1:0]     value_r, value_nxt;
  logic [llds_pkg::TOTAL_W-1:0]     acc_r, acc_nxt;

  logic                             out_valid_r, out_valid_nxt;
  llds_pkg::status_t                out_status_r, out_status_nxt;
  logic [llds_pkg::TOTAL_W-1:0]     out_total_r, out_total_nxt;
  logic [llds_pkg::CNT_W-1:0]       out_cnt_r, out_cnt_nxt;

  llds_pkg::cell_ctl_t              ctl;
  logic [llds_pkg::VALUE_W-1:0]     head_data;
  logic [llds_pkg::IDX_W-1:0]       tail_full;
  logic                             out_free;
  logic                             accept;
  logic                             last_step;
  logic                             step_en;
  logic                             head_match;
  logic                             drop_head;
  llds_pkg::kind_t                  in_kind;

  // Handshake
  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) && out_free;
  assign accept         = in_chan.valid && in_chan.ready;
  assign in_kind        = llds_pkg::kind_t'(in_chan.kind);

  // Scan step control
  assign last_step  = (steps_r == llds_pkg::CNT_W'(1));
  assign step_en    = (state_r == S_SCAN) && (!last_step || out_free);
  assign head_match = (head_data == value_r);
  assign drop_head  = (op_r == llds_pkg::KIND_DELETE) && !found_r && head_match;
  assign tail_full  = llds_pkg::IDX_W'(count_r - llds_pkg::CNT_W'(1)
                    - llds_pkg::CNT_W'((op_r == llds_pkg::KIND_DELETE) && found_r));

  // Cell broadcast
  always_comb begin
    ctl.push      = accept && (in_kind == llds_pkg::KIND_INSERT)
                    && (count_r < llds_pkg::CNT_W'(llds_pkg::DEPTH));
    ctl.scan      = step_en;
    ctl.keep_head = !drop_head;
    ctl.tail_idx  = tail_full;
  end

  llds_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .push_data (in_chan.value),
    .head_data (head_data)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    out_cnt_nxt    = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_kind;
          value_nxt = in_chan.value;
          steps_nxt = count_r;
          found_nxt = 1'b0;
          acc_nxt   = '0;
          if (in_kind == llds_pkg::KIND_INSERT) begin
            out_valid_nxt = 1'b1;
            out_total_nxt = '0;
            if (count_r < llds_pkg::CNT_W'(llds_pkg::DEPTH)) begin
              count_nxt      = count_r + llds_pkg::CNT_W'(1);
              out_status_nxt = llds_pkg::STAT_OK;
              out_cnt_nxt    = count_r + llds_pkg::CNT_W'(1);
            end else begin
              out_status_nxt = llds_pkg::STAT_FULL;
              out_cnt_nxt    = count_r;
            end
          end else if (count_r == '0) begin
            // Empty list answers at once
            out_valid_nxt  = 1'b1;
            out_total_nxt  = '0;
            out_cnt_nxt    = count_r;
            out_status_nxt = (in_kind == llds_pkg::KIND_SEARCH) ?
                             llds_pkg::STAT_ABSENT : llds_pkg::STAT_EMPTY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (step_en) begin
          steps_nxt = steps_r - llds_pkg::CNT_W'(1);
          found_nxt = found_r || head_match;
          if ((op_r == llds_pkg::KIND_SUM) && !head_data[llds_pkg::VALUE_W-1]) begin
            acc_nxt = acc_r + llds_pkg::TOTAL_W'(head_data);
          end
          if (last_step) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_total_nxt = '0;
            case (op_r)
              llds_pkg::KIND_DELETE: begin
                if (found_nxt) begin
                  count_nxt      = count_r - llds_pkg::CNT_W'(1);
                  out_status_nxt = llds_pkg::STAT_OK;
                  out_cnt_nxt    = count_r - llds_pkg::CNT_W'(1);
                end else begin
                  out_status_nxt = llds_pkg::STAT_ABSENT;
                  out_cnt_nxt    = count_r;
                end
              end
              llds_pkg::KIND_SEARCH: begin
                out_status_nxt = found_nxt ? llds_pkg::STAT_OK : llds_pkg::STAT_ABSENT;
                out_cnt_nxt    = count_r;
              end
              default: begin
                out_status_nxt = llds_pkg::STAT_OK;
                out_total_nxt  = acc_nxt;
                out_cnt_nxt    = count_r;
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    found_r      <= found_nxt;
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    acc_r        <= acc_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // Result channel; count is sized to its field width
  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.total  = out_total_r;
  assign out_chan.count  = llds_pkg::COUNT_W'(out_cnt_r);

endmodule

/* sim/tb_lifo_list_delete_search.sv */
// ----------------------------------------------------------------------------
// tb_lifo_list_delete_search
// Self-checking bench for the newest-first value list. A short table of
// directed operations covers the empty, full and extreme-value corner cases.
// Biased random traffic follows: fill, drain and balanced phases with values
// drawn mostly from a small pool, so deletes and searches hit. Every result
// is checked against its table row or an in-bench model of the list. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_lifo_list_delete_search;
  timeunit 1ns;
  timeprecision 1ps;

  import llds_pkg::*;

  localparam int RAND_ITEMS  = 1625;
  localparam int PHASE_LEN   = 150;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    status_t              status;
    logic [TOTAL_W-1:0]   total;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  typedef struct {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;  // expectation written into the table
    list_result_t              want;
  } list_op_t;

  logic clk;
  logic rst_n;

  llds_in_if  in_ch ();
  llds_out_if out_ch ();

  lifo_list_delete_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Model of the list: slot 0 is the head
  logic signed [VALUE_W-1:0] held [DEPTH];
  int unsigned               held_n;

  list_result_t pending_results[$];
  list_op_t     op_plan[$];

  // Table expectation travelling alongside the payload
  bit           row_typed;
  list_result_t row_want;

  int  mismatches;
  int  kind_tally[4];
  int  status_tally[4];
  int  mode;
  bit  calm;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset
  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one operation to the model and return the result it gives
  function automatic list_result_t apply_list_op(kind_t k, logic signed [VALUE_W-1:0] v);
    list_result_t res;
    int           slot;
    res.status = STAT_OK;
    res.total  = '0;
    slot       = -1;
    for (int i = 0; i < held_n; i++) begin
      if (slot < 0 && held[i] == v) slot = i;
    end
    case (k)
      KIND_INSERT: begin
        if (held_n >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = held_n; i > 0; i--) held[i] = held[i-1];
          held[0] = v;
          held_n++;
        end
      end
      KIND_DELETE: begin
        if (held_n == 0) begin
          res.status = STAT_EMPTY;
        end else if (slot < 0) begin
          res.status = STAT_ABSENT;
        end else begin
          for (int i = slot; i + 1 < held_n; i++) held[i] = held[i+1];
          held_n--;
        end
      end
      KIND_SEARCH: begin
        if (slot < 0) res.status = STAT_ABSENT;
      end
      default: begin
        if (held_n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < held_n; i++) begin
            if (held[i] > 0) res.total = res.total + {3'b000, held[i]};
          end
        end
      end
    endcase
    res.count = COUNT_W'(held_n);
    return res;
  endfunction

  // Idle length: mostly short, a few long, none in calm phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pool_value(int idx);
    case (idx)
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'sd7;
      4:       return -32'sd7;
      5:       return 32'sh7FFF_FFFF;
      6:       return 32'sh8000_0000;
      default: return 32'sd1000;
    endcase
  endfunction

  // Mostly pool values and values already held, so deletes and searches hit
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return pool_value($urandom_range(0, 7));
    if (r < 80 && held_n > 0) return held[$urandom_range(0, held_n - 1)];
    return $urandom;
  endfunction

  // Operation mix follows the phase: fill, drain or balanced
  function automatic kind_t pick_kind();
    int r;
    int ins_w;
    int del_w;
    r     = $urandom_range(0, 99);
    ins_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 25;
    del_w = (mode == 1) ? 55 : (mode == 0) ? 15 : 25;
    if (r < ins_w) return KIND_INSERT;
    if (r < ins_w + del_w) return KIND_DELETE;
    if (r < ins_w + del_w + (100 - ins_w - del_w) / 2) return KIND_SEARCH;
    return KIND_SUM;
  endfunction

  task automatic add_row(kind_t k, logic signed [VALUE_W-1:0] v, bit typed,
                         status_t st, logic [TOTAL_W-1:0] tot,
                         logic [COUNT_W-1:0] cnt);
    list_op_t row;
    row.kind        = k;
    row.value       = v;
    row.typed       = typed;
    row.want.status = st;
    row.want.total  = tot;
    row.want.count  = cnt;
    op_plan.push_back(row);
  endtask

  // Present one request and wait for its transaction; valid stays high
  // across back-to-back requests
  task automatic issue(list_op_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= row.kind;
    in_ch.value <= row.value;
    row_typed   <= row.typed;
    row_want    <= row.want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result side back-pressure
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Check results in order, then record the request taken at this edge
  always @(posedge clk) begin : monitor
    list_result_t got;
    list_result_t want;
    list_result_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.total  = out_ch.total;
        got.count  = out_ch.count;
        status_tally[got.status]++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: status %0d total %0h count %0d",
                     $realtime, got.status, got.total, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status || got.total != want.total ||
              got.count != want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch: status %0d/%0d total %0h/%0h count %0d/%0d (exp/act)",
                       $realtime, want.status, got.status, want.total, got.total,
                       want.count, got.count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = apply_list_op(kind_t'(in_ch.kind), in_ch.value);
        kind_tally[in_ch.kind]++;
        pending_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    list_op_t row;
    int       wait_cycles;
    held_n      = 0;
    mismatches  = 0;
    mode        = 2;
    calm        = 1'b0;
    row_typed   = 1'b0;
    row_want    = '0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_INSERT;
    in_ch.value <= '0;

    // Directed table: empty list, extremes, not found, full list, largest sum
    add_row(KIND_SUM,    32'sd0,           1, STAT_EMPTY,  '0, 5'd0);
    add_row(KIND_DELETE, 32'sd0,           1, STAT_EMPTY,  '0, 5'd0);
    add_row(KIND_SEARCH, 32'sd0,           1, STAT_ABSENT, '0, 5'd0);
    add_row(KIND_INSERT, 32'sh7FFF_FFFF,   1, STAT_OK,     '0, 5'd1);
    add_row(KIND_INSERT, 32'sh8000_0000,   1, STAT_OK,     '0, 5'd2);
    add_row(KIND_SUM,    32'sh8000_0000,   1, STAT_OK,     35'h0_7FFF_FFFF, 5'd2);
    add_row(KIND_SEARCH, 32'sh8000_0000,   1, STAT_OK,     '0, 5'd2);
    add_row(KIND_DELETE, 32'sd5,           1, STAT_ABSENT, '0, 5'd2);
    add_row(KIND_DELETE, 32'sh8000_0000,   1, STAT_OK,     '0, 5'd1);
    for (int i = 0; i < DEPTH - 1; i++)
      add_row(KIND_INSERT, 32'sh7FFF_FFFF, 0, STAT_OK,     '0, '0);
    add_row(KIND_INSERT, -32'sd1,          1, STAT_FULL,   '0, 5'd16);
    add_row(KIND_SUM,    -32'sd1,          1, STAT_OK,     35'h7_FFFF_FFF0, 5'd16);
    add_row(KIND_SEARCH, -32'sd1,          1, STAT_ABSENT, '0, 5'd16);

    wait (rst_n === 1'b1);
    @(posedge clk);
    foreach (op_plan[i]) issue(op_plan[i]);

    // Random traffic in phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        mode = $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
      end
      row.kind  = pick_kind();
      row.value = pick_value();
      row.typed = 1'b0;
      row.want  = '0;
      issue(row);
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for any stray late result
    while (pending_results.size() > 0) @(posedge clk);
    wait_cycles = TAIL_CYCLES;
    repeat (wait_cycles) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("Operations: %0d insert, %0d delete, %0d search, %0d sum",
             kind_tally[KIND_INSERT], kind_tally[KIND_DELETE],
             kind_tally[KIND_SEARCH], kind_tally[KIND_SUM]);
    $display("Results by status: ok %0d, full %0d, empty %0d, not found %0d; mismatches %0d",
             status_tally[STAT_OK], status_tally[STAT_FULL],
             status_tally[STAT_EMPTY], status_tally[STAT_ABSENT], mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
